[rtl/stnm_pkg.sv]
package stnm_pkg;

  localparam int SLOTS_DEFAULT      = 32;
  localparam int COORD_BITS_DEFAULT = 6;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_FIND    = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [1:0] ST_NO_MATCH  = 2'd3;

  localparam int DIST_MAX = 127;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] kind;
    logic [2:0] owner;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [4:0] slot_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] result_slot;
    logic [6:0] distance;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic alloc_rd;
    logic alloc_wr;
    logic release_op;
    logic scan_step;
    logic res_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/stnm_ram.sv]
module stnm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/stnm_datapath.sv]
module stnm_datapath #(
  parameter int SLOTS      = 32,
  parameter int COORD_BITS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  stnm_pkg::ctl_cmd_t  ctl,
  output stnm_pkg::dp_stat_t  stat,
  input  stnm_pkg::in_item_t  cmd_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output stnm_pkg::out_item_t rsp_data
);
  import stnm_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int DW     = COORD_BITS + 1;
  localparam int XW     = (SLOT_W > 5) ? SLOT_W : 5;
  localparam int IDW    = XW + 1;
  localparam int SW     = (DW > 7) ? DW : 7;
  localparam int REC_W  = 4 + 3 + 2 * COORD_BITS;

  // request
  logic [1:0]            q_cmd;
  logic [3:0]            q_kind;
  logic [2:0]            q_owner;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  logic [4:0]            q_sid;

  // table state
  logic [SLOTS-1:0] slot_valid;
  logic [SLOTS-1:0] stack_written;
  logic [CNT_W-1:0] used_count;

  // pending result for allocate and release
  logic [1:0] res_status;
  logic [4:0] res_slot;

  // scan
  logic [SLOT_W-1:0] scan_idx;
  logic              p_live;
  logic [SLOT_W-1:0] p_idx;
  logic              found;
  logic [DW-1:0]     best_d;
  logic [SLOT_W-1:0] best_id;

  logic [CNT_W-1:0]  used_dec;
  logic [SLOT_W-1:0] used_idx;
  logic [SLOT_W-1:0] stack_rdata;
  logic [SLOT_W-1:0] pop_id;
  logic [XW-1:0]     pop_wide;
  logic [XW-1:0]     best_wide;
  logic [IDW-1:0]    sid_ext;
  logic [SLOT_W-1:0] sid_idx;
  logic              rel_ok;
  logic [REC_W-1:0]  rec_wdata;
  logic [REC_W-1:0]  rec;
  logic [3:0]            r_kind;
  logic [2:0]            r_owner;
  logic [COORD_BITS-1:0] r_x;
  logic [COORD_BITS-1:0] r_y;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [COORD_BITS-1:0] m;
  logic [DW-1:0]     d;
  logic              hit;
  logic              better;
  logic [SW-1:0]     best_sw;
  logic [6:0]        dist_sat;
  out_item_t         res_mux;

  assign used_dec = used_count - CNT_W'(1);
  assign used_idx = used_count[SLOT_W-1:0];
  assign pop_id   = stack_written[used_idx] ? stack_rdata : used_idx;
  assign pop_wide = XW'(pop_id);
  assign best_wide = XW'(best_id);

  assign sid_ext = IDW'(q_sid);
  assign sid_idx = sid_ext[SLOT_W-1:0];
  assign rel_ok  = (sid_ext < IDW'(SLOTS)) && slot_valid[sid_idx] && (used_count != '0);

  assign rec_wdata = {q_kind, q_owner, q_x, q_y};
  assign r_kind  = rec[REC_W-1 -: 4];
  assign r_owner = rec[REC_W-5 -: 3];
  assign r_x     = rec[2*COORD_BITS-1 -: COORD_BITS];
  assign r_y     = rec[COORD_BITS-1:0];

  stnm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (ctl.release_op & rel_ok),
    .waddr (used_dec[SLOT_W-1:0]),
    .wdata (sid_idx),
    .raddr (used_idx),
    .rdata (stack_rdata)
  );

  stnm_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (ctl.alloc_wr),
    .waddr (pop_id),
    .wdata (rec_wdata),
    .raddr (scan_idx),
    .rdata (rec)
  );

  // octagonal distance of the record read last cycle
  always_comb begin
    dx = (r_x > q_x) ? r_x - q_x : q_x - r_x;
    dy = (r_y > q_y) ? r_y - q_y : q_y - r_y;
    m  = (dx < dy) ? dx : dy;
    d  = DW'(dx) + DW'(dy) - DW'(m >> 2) - DW'(m >> 3) + DW'(m >> 5);
    hit    = p_live && (r_kind == q_kind) && (r_owner == q_owner);
    better = hit && (!found || (d < best_d));
  end

  always_comb begin
    best_sw  = SW'(best_d);
    dist_sat = (best_sw > SW'(DIST_MAX)) ? 7'(DIST_MAX) : best_sw[6:0];
    if (q_cmd == CMD_FIND) begin
      if (found) begin
        res_mux.status      = ST_OK;
        res_mux.result_slot = best_wide[4:0];
        res_mux.distance    = dist_sat;
      end else begin
        res_mux.status      = ST_NO_MATCH;
        res_mux.result_slot = '0;
        res_mux.distance    = '0;
      end
    end else begin
      res_mux.status      = res_status;
      res_mux.result_slot = res_slot;
      res_mux.distance    = '0;
    end
  end

  assign stat.full      = (used_count >= CNT_W'(SLOTS));
  assign stat.scan_last = (scan_idx == SLOT_W'(SLOTS - 1));
  assign stat.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_cmd      <= cmd_data.command;
      q_kind     <= cmd_data.kind;
      q_owner    <= cmd_data.owner;
      q_x        <= COORD_BITS'(cmd_data.pos_x);
      q_y        <= COORD_BITS'(cmd_data.pos_y);
      q_sid      <= cmd_data.slot_id;
      res_status <= ST_OK;
      res_slot   <= (cmd_data.command == CMD_RELEASE) ? cmd_data.slot_id : 5'd0;
    end
    if (ctl.alloc_rd && stat.full) begin
      res_status <= ST_FULL;
    end
    if (ctl.alloc_wr) begin
      res_slot <= pop_wide[4:0];
    end
    if (ctl.release_op && !rel_ok) begin
      res_status <= ST_NOT_ALLOC;
    end
    p_idx <= scan_idx;
    if (better) begin
      best_d  <= d;
      best_id <= p_idx;
    end
    if (ctl.res_load) begin
      rsp_data <= res_mux;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      stack_written <= '0;
      used_count    <= '0;
      scan_idx      <= '0;
      p_live        <= 1'b0;
      found         <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      if (ctl.alloc_wr) begin
        slot_valid[pop_id] <= 1'b1;
        used_count         <= used_count + CNT_W'(1);
      end
      if (ctl.release_op && rel_ok) begin
        slot_valid[sid_idx]                  <= 1'b0;
        stack_written[used_dec[SLOT_W-1:0]] <= 1'b1;
        used_count                           <= used_dec;
      end
      p_live <= ctl.scan_step && slot_valid[scan_idx];
      if (ctl.load) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (ctl.scan_step && !stat.scan_last) begin
          scan_idx <= scan_idx + SLOT_W'(1);
        end
        if (better) begin
          found <= 1'b1;
        end
      end
      if (ctl.res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

[rtl/stnm_ctrl.sv]
module stnm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic [1:0]         command,
  input  stnm_pkg::dp_stat_t stat,
  output logic               cmd_ready,
  output stnm_pkg::ctl_cmd_t ctl
);
  import stnm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ALLOC_RD = 7'b0000010,
    S_ALLOC_WR = 7'b0000100,
    S_RELEASE  = 7'b0001000,
    S_SCAN     = 7'b0010000,
    S_DRAIN    = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.load = 1'b1;
          case (command)
            CMD_ALLOC:   state_next = S_ALLOC_RD;
            CMD_RELEASE: state_next = S_RELEASE;
            CMD_FIND:    state_next = S_SCAN;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_ALLOC_RD: begin
        ctl.alloc_rd = 1'b1;
        state_next   = stat.full ? S_DONE : S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        ctl.alloc_wr = 1'b1;
        state_next   = S_DONE;
      end
      S_RELEASE: begin
        ctl.release_op = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last compare lands this cycle
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          ctl.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/slot_table_nearest_match.sv]
// Channel  Direction  Handshake              Payload
// cmd      in         cmd_valid / cmd_ready  cmd_data (in_item_t)
// rsp      out        rsp_valid / rsp_ready  rsp_data (out_item_t)
//
// One transaction at a time. Allocate reads, then writes (no write on a
// full table); find reads one slot record per cycle through the slot RAM's
// read port, then a drain state waits for the last compare.
// Reset is synchronous; the table comes up empty with no clearing pass.
// A waiting result blocks the next transaction only once that one is
// ready to deliver.
module slot_table_nearest_match #(
  parameter int SLOTS      = stnm_pkg::SLOTS_DEFAULT,
  parameter int COORD_BITS = stnm_pkg::COORD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  stnm_pkg::in_item_t  cmd_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output stnm_pkg::out_item_t rsp_data
);
  import stnm_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  stnm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .command   (cmd_data.command),
    .stat      (stat),
    .cmd_ready (cmd_ready),
    .ctl       (ctl)
  );

  stnm_datapath #(.SLOTS(SLOTS), .COORD_BITS(COORD_BITS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .stat      (stat),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("cmd_ready stayed high after an accepted transaction");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> stat.out_free)
    else $error("result loaded over an undelivered result");

  a_single_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.alloc_rd, ctl.alloc_wr, ctl.release_op,
              ctl.scan_step, ctl.res_load}))
    else $error("controller issued more than one command");

  a_distance_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.distance != 7'd0)) |-> (rsp_data.status == ST_OK))
    else $error("nonzero distance on a failed transaction");
endmodule

[test/slot_table_scoreboard.sv]
`timescale 1ns / 100ps
module slot_table_scoreboard (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  input  logic                               cmd_ready,
  input  stnm_pkg::in_item_t                 cmd_data,
  input  logic                               rsp_valid,
  input  logic                               rsp_ready,
  input  stnm_pkg::out_item_t                rsp_data,
  output int                                 errors,
  output int                                 pending,
  output logic [stnm_pkg::SLOTS_DEFAULT-1:0] live_slots
);
  import stnm_pkg::*;

  localparam int NSLOT = SLOTS_DEFAULT;

  logic [NSLOT-1:0] occupied;
  logic [3:0]       kind_tab  [NSLOT];
  logic [2:0]       owner_tab [NSLOT];
  logic [5:0]       x_tab     [NSLOT];
  logic [5:0]       y_tab     [NSLOT];
  logic [4:0]       free_ids  [NSLOT];
  int               used_count;
  int               mismatch_count;
  out_item_t        expected_replies [$];

  // Update the shadow table for one command and return the reply it should produce.
  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t  r;
    logic       hit;
    int         best;
    int         d;
    int         dx;
    int         dy;
    int         m;
    logic [4:0] id;
    r = '0;
    case (c.command)
      CMD_ALLOC: begin
        if (used_count >= NSLOT) begin
          r.status = ST_FULL;
        end else begin
          id = free_ids[used_count];
          used_count++;
          occupied[id] = 1'b1;
          kind_tab[id] = c.kind;
          owner_tab[id] = c.owner;
          x_tab[id] = c.pos_x;
          y_tab[id] = c.pos_y;
          r.result_slot = id;
        end
      end
      CMD_RELEASE: begin
        r.result_slot = c.slot_id;
        if (!occupied[c.slot_id] || used_count == 0) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          used_count--;
          free_ids[used_count] = c.slot_id;
          occupied[c.slot_id] = 1'b0;
        end
      end
      CMD_FIND: begin
        hit = 1'b0;
        best = 0;
        for (int i = 0; i < NSLOT; i++) begin
          if (occupied[i] && kind_tab[i] == c.kind && owner_tab[i] == c.owner) begin
            dx = int'(x_tab[i]) - int'(c.pos_x);
            dy = int'(y_tab[i]) - int'(c.pos_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            m = (dx < dy) ? dx : dy;
            d = dx + dy - m / 4 - m / 8 + m / 32;
            // strictly smaller only, so the lowest index keeps a tie
            if (!hit || d < best) begin
              hit = 1'b1;
              best = d;
              r.result_slot = 5'(i);
            end
          end
        end
        if (hit) begin
          r.distance = (best > DIST_MAX) ? 7'(DIST_MAX) : 7'(best);
        end else begin
          r.status = ST_NO_MATCH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_failure(input string what, input out_item_t want,
                                      input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: expected status %0d slot %0d dist %0d,",
               $time, what, want.status, want.result_slot, want.distance,
               " got status %0d slot %0d dist %0d",
               got.status, got.result_slot, got.distance);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      occupied = '0;
      for (int i = 0; i < NSLOT; i++) free_ids[i] = 5'(i);
      used_count = 0;
      mismatch_count = 0;
      expected_replies.delete();
    end else begin
      // retire the reply first: it can never belong to a command taken on the same edge
      if (rsp_valid && rsp_ready) begin
        if (expected_replies.size() == 0) begin
          log_failure("unexpected reply", '0, rsp_data);
        end else begin
          want = expected_replies.pop_front();
          if (rsp_data.status !== want.status || rsp_data.result_slot !== want.result_slot ||
              rsp_data.distance !== want.distance)
            log_failure("reply mismatch", want, rsp_data);
        end
      end
      if (cmd_valid && cmd_ready) expected_replies.push_back(apply_command(cmd_data));
    end
    errors <= mismatch_count;
    pending <= expected_replies.size();
    live_slots <= occupied;
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import stnm_pkg::*;

  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS   = 550;
  localparam int         QUIET_TAIL     = 60;
  localparam int         LONG_HOLD      = 400;
  localparam int         WATCHDOG_LIMIT = 3000;
  localparam int         DRAIN_CYCLES   = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  in_item_t  cmd_data = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp_data;

  int                       fail_count;
  int                       pending;
  logic [SLOTS_DEFAULT-1:0] live_slots;
  logic                     quiet = 1'b0;
  logic                     pressure_go = 1'b0;
  int                       stall_cycles = 0;

  always #10 clk = ~clk;

  slot_table_nearest_match uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  slot_table_scoreboard scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd_data   (cmd_data),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp_data   (rsp_data),
    .errors     (fail_count),
    .pending    (pending),
    .live_slots (live_slots)
  );

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t item_of(input logic [1:0] command, input logic [3:0] kind,
                                       input logic [2:0] owner, input logic [5:0] x,
                                       input logic [5:0] y, input logic [4:0] id);
    in_item_t it;
    it.command = command;
    it.kind = kind;
    it.owner = owner;
    it.pos_x = x;
    it.pos_y = y;
    it.slot_id = id;
    return it;
  endfunction

  // mode 0 fills the table, 1 drains it, 2 mixes
  function automatic in_item_t random_item(input int mode);
    in_item_t it;
    int       roll;
    int       alloc_lim;
    int       find_lim;
    int       start;
    it = in_item_t'($urandom);
    roll = $urandom_range(0, 99);
    alloc_lim = (mode == 0) ? 70 : (mode == 1) ? 10 : 35;
    find_lim = alloc_lim + ((mode == 1) ? 25 : 30);
    if (roll >= 98) it.command = CMD_UNUSED;
    else if (roll < alloc_lim) it.command = CMD_ALLOC;
    else if (roll < find_lim) it.command = CMD_FIND;
    else it.command = CMD_RELEASE;
    // keep kinds and owners in a narrow set so finds mostly hit something
    if ($urandom_range(0, 4) != 0) begin
      it.kind = 4'($urandom_range(0, 2));
      it.owner = 3'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 9) == 0) it.pos_x = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    if ($urandom_range(0, 9) == 0) it.pos_y = $urandom_range(0, 1) ? 6'd63 : 6'd0;
    if (it.command == CMD_RELEASE && live_slots != '0 && $urandom_range(0, 6) != 0) begin
      start = $urandom_range(0, SLOTS_DEFAULT - 1);
      for (int i = 0; i < SLOTS_DEFAULT; i++) begin
        if (live_slots[(start + i) % SLOTS_DEFAULT]) begin
          it.slot_id = 5'((start + i) % SLOTS_DEFAULT);
          break;
        end
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data <= it;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
  endtask

  // reply side: random ready/stall bursts, one long hold to back up the command side
  initial begin
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (pressure_go && !held) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  initial begin
    int mode;
    int phase_left;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(item_of(CMD_FIND, 4'd15, 3'd7, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd31));
    send_item(item_of(CMD_UNUSED, 4'd15, 3'd7, 6'd63, 6'd63, 5'd31));
    send_item(item_of(CMD_ALLOC, 4'd15, 3'd7, 6'd63, 6'd63, 5'd0));
    send_item(item_of(CMD_ALLOC, 4'd0, 3'd0, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_ALLOC, 4'd15, 3'd7, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_FIND, 4'd15, 3'd7, 6'd0, 6'd0, 5'd0));
    // equal distance to two slots: lower index wins
    send_item(item_of(CMD_FIND, 4'd15, 3'd7, 6'd63, 6'd0, 5'd0));
    send_item(item_of(CMD_FIND, 4'd0, 3'd0, 6'd63, 6'd63, 5'd0));
    send_item(item_of(CMD_FIND, 4'd15, 3'd6, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_FIND, 4'd14, 3'd7, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd1));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd1));
    send_item(item_of(CMD_FIND, 4'd0, 3'd0, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_ALLOC, 4'd5, 3'd3, 6'd21, 6'd42, 5'd0));
    send_item(item_of(CMD_ALLOC, 4'd5, 3'd3, 6'd42, 6'd21, 5'd0));
    send_item(item_of(CMD_FIND, 4'd5, 3'd3, 6'd31, 6'd31, 5'd0));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd0));
    send_item(item_of(CMD_RELEASE, 4'd0, 3'd0, 6'd0, 6'd0, 5'd2));
    send_item(item_of(CMD_FIND, 4'd15, 3'd7, 6'd0, 6'd0, 5'd0));

    pressure_go <= 1'b1;
    mode = 0;
    phase_left = $urandom_range(30, 70);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet <= 1'b1;
      if (phase_left == 0) begin
        mode = (mode + 1) % 3;
        phase_left = $urandom_range(30, 70);
      end
      phase_left--;
      send_item(random_item(mode));
    end
    cmd_valid <= 1'b0;

    // let the last transaction show up in the pending count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
